### sv/tfa_pkg.sv
// ============================================================================
// tfa_pkg - shared types and constants for the two resource fit allocator
// Request/response beat layouts, the token that walks the server cell chain,
// and the opcode, status, fit mode and register index codes.
// ============================================================================
package tfa_pkg;

    // Server table size and field widths
    localparam int NUM_SERVERS_DEF = 128;
    localparam int SRV_W   = 7;
    localparam int CORE_W  = 5;
    localparam int MEM_W   = 7;
    localparam int WASTE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Reset capacities
    localparam logic [CORE_W-1:0] RST_CORES = 5'd24;
    localparam logic [MEM_W-1:0]  RST_MEM   = 7'd64;

    // Request kinds
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_GRANT   = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;
    localparam logic [1:0] ST_CLAMP   = 2'd3;

    // Placement policies
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_CORES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_MEM   = 2'd2;

    // Request beat
    typedef struct packed {
        logic              op;
        logic [CORE_W-1:0] core_need;
        logic [MEM_W-1:0]  memory_need;
        logic [SRV_W-1:0]  target_server;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [1:0]        status;
        logic [SRV_W-1:0]  chosen_server;
        logic [CORE_W-1:0] cores_left;
        logic [MEM_W-1:0]  memory_left;
    } t_rsp;

    // Per-cell view of the configuration
    typedef struct packed {
        logic [1:0]        fit_mode;
        logic [CORE_W-1:0] cap_cores;
        logic [MEM_W-1:0]  cap_mem;
    } t_cell_cfg;

    // Refill of the server counts, sent to every cell
    typedef struct packed {
        logic              refill;
        logic [CORE_W-1:0] fill_cores;
        logic [MEM_W-1:0]  fill_mem;
    } t_fill;

    // Token handed from cell to cell, carrying the request and best so far
    typedef struct packed {
        logic               valid;
        t_req               req;
        logic               found;
        logic [WASTE_W-1:0] best_waste;
        t_rsp               rsp;
    } t_tok;

endpackage

### sv/tfa_cell.sv
// ============================================================================
// tfa_cell - one server entry of the allocator chain
// Holds the free core and memory counts of one server. Each cycle it checks
// the incoming token against its counts, updates the best candidate (or the
// release result when it is the target) and registers the token onward.
// ============================================================================
module tfa_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfa_pkg::t_cell_cfg i_cfg,
    input  tfa_pkg::t_fill    i_fill,
    input  logic              i_wr_en,
    input  tfa_pkg::t_rsp     i_wr,
    input  tfa_pkg::t_tok     i_tok,
    output tfa_pkg::t_tok     o_tok
);
    import tfa_pkg::*;

    localparam logic [SRV_W-1:0] IDX = SRV_W'(CELL_IDX);

    logic [CORE_W-1:0]  r_cores;
    logic [MEM_W-1:0]   r_mem;
    t_tok               r_tok;
    t_tok               n_tok;

    logic               fits;
    logic [CORE_W-1:0]  cores_after;
    logic [MEM_W-1:0]   mem_after;
    logic [WASTE_W-1:0] waste;
    logic               better;
    logic [CORE_W:0]    rel_cores;
    logic [MEM_W:0]     rel_mem;
    logic               clamp_c;
    logic               clamp_m;

    // Fit check and leftover for an allocate
    always_comb begin
        fits = (i_cfg.fit_mode == FIT_FIRST || i_cfg.fit_mode == FIT_BEST ||
                i_cfg.fit_mode == FIT_WORST) &&
               (r_cores >= i_tok.req.core_need) && (r_mem >= i_tok.req.memory_need);
        cores_after = r_cores - i_tok.req.core_need;
        mem_after   = r_mem - i_tok.req.memory_need;
        waste  = WASTE_W'(cores_after) + WASTE_W'(mem_after);
        better = !i_tok.found ||
                 (i_cfg.fit_mode == FIT_BEST  && waste < i_tok.best_waste) ||
                 (i_cfg.fit_mode == FIT_WORST && waste > i_tok.best_waste);
    end

    // Credit with clamp for a release
    always_comb begin
        rel_cores = {1'b0, r_cores} + {1'b0, i_tok.req.core_need};
        rel_mem   = {1'b0, r_mem} + {1'b0, i_tok.req.memory_need};
        clamp_c   = rel_cores > {1'b0, i_cfg.cap_cores};
        clamp_m   = rel_mem > {1'b0, i_cfg.cap_mem};
    end

    // Token update
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (i_tok.req.op == OP_ALLOC) begin
                if (fits && better) begin
                    n_tok.found             = 1'b1;
                    n_tok.best_waste        = waste;
                    n_tok.rsp.status        = ST_GRANT;
                    n_tok.rsp.chosen_server = IDX;
                    n_tok.rsp.cores_left    = cores_after;
                    n_tok.rsp.memory_left   = mem_after;
                end
            end else if (i_tok.req.target_server == IDX) begin
                n_tok.found             = 1'b1;
                n_tok.rsp.status        = (clamp_c || clamp_m) ? ST_CLAMP : ST_RELEASE;
                n_tok.rsp.chosen_server = IDX;
                n_tok.rsp.cores_left    = clamp_c ? i_cfg.cap_cores : rel_cores[CORE_W-1:0];
                n_tok.rsp.memory_left   = clamp_m ? i_cfg.cap_mem : rel_mem[MEM_W-1:0];
            end
        end
    end

    // Token stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Server counts: reset, refill on capacity write, commit at end of scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cores <= RST_CORES;
            r_mem   <= RST_MEM;
        end else if (i_fill.refill) begin
            r_cores <= i_fill.fill_cores;
            r_mem   <= i_fill.fill_mem;
        end else if (i_wr_en) begin
            r_cores <= i_wr.cores_left;
            r_mem   <= i_wr.memory_left;
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/two_resource_fit_allocator_core.sv
// o_done rises as the token leaves the last cell, after passing the token register of each
// server cell in order; the result is taken at the edge that ends the o_done cycle.
// A new request is taken only once busy falls, after the token has walked the
// server cell chain one cell per cycle; busy stays high through the result cycle.
// The receiver cannot stall; the chosen server is written back as the result is taken.
// Reset (synchronous, active low) sets every server to 24 cores and 64 memory.
// ============================================================================
// two_resource_fit_allocator_core - first/best/worst fit server allocator
// Keeps per-server free core and memory counts in a chain of cells, places
// allocate requests by policy and credits release requests with clamping.
// ============================================================================
module two_resource_fit_allocator_core #(
    parameter int NUM_SERVERS = tfa_pkg::NUM_SERVERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request beat
    input  logic                             start,
    output logic                             busy,
    input  tfa_pkg::t_req                    i_req,
    // response beat
    output logic                             o_done,
    output tfa_pkg::t_rsp                    o_rsp,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tfa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tfa_pkg::*;

    logic              r_busy;
    logic [1:0]        r_fit_mode;
    logic [CORE_W-1:0] r_cap_cores;
    logic [MEM_W-1:0]  r_cap_mem;

    t_tok              w_tok [NUM_SERVERS+1];
    t_tok              head_tok;
    t_cell_cfg         cell_cfg;
    t_fill             fill;
    t_tok              last;
    logic              cfg_wr;
    logic              accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign accept      = start && !r_busy;
    assign busy        = r_busy;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode  <= FIT_FIRST;
            r_cap_cores <= RST_CORES;
            r_cap_mem   <= RST_MEM;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_FIT_MODE:  r_fit_mode  <= i_cfg_data[1:0];
                CFG_CAP_CORES: r_cap_cores <= i_cfg_data[CORE_W-1:0];
                CFG_CAP_MEM:   r_cap_mem   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Refill uses the value being written so cells load in the same cycle
    always_comb begin
        fill.refill     = cfg_wr && (i_cfg_index == CFG_CAP_CORES ||
                                     i_cfg_index == CFG_CAP_MEM);
        fill.fill_cores = (i_cfg_index == CFG_CAP_CORES) ?
                          i_cfg_data[CORE_W-1:0] : r_cap_cores;
        fill.fill_mem   = (i_cfg_index == CFG_CAP_MEM) ? i_cfg_data : r_cap_mem;
        cell_cfg.fit_mode  = r_fit_mode;
        cell_cfg.cap_cores = r_cap_cores;
        cell_cfg.cap_mem   = r_cap_mem;
    end

    // Token entering the chain: no server found yet, answer defaults to no fit
    always_comb begin
        head_tok            = '0;
        head_tok.valid      = accept;
        head_tok.req        = i_req;
        head_tok.found      = 1'b0;
        head_tok.rsp.status = ST_NOFIT;
    end

    assign w_tok[0] = head_tok;

    // Chain of server cells
    for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_cell
        logic wr_en;
        assign wr_en = last.valid && last.found &&
                       (last.rsp.chosen_server == SRV_W'(g));
        tfa_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cell_cfg),
            .i_fill  (fill),
            .i_wr_en (wr_en),
            .i_wr    (last.rsp),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign last = w_tok[NUM_SERVERS];

    // Busy from the start edge until the result cycle ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (last.valid) begin
            r_busy <= 1'b0;
        end
    end

    // Result beat straight from the last cell stage
    assign o_done = last.valid;
    assign o_rsp  = last.rsp;

endmodule

### tb/tfa_reply_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// tfa_reply_checker - reply predictor and scoreboard for the fit allocator
// Watches the request, reply and register channels of the allocator, keeps
// its own copy of the server table and policy, works out each reply when a
// request beat is taken and compares every reply beat with the oldest one.
// ============================================================================
module tfa_reply_checker #(
    parameter int NUM_SERVERS = tfa_pkg::NUM_SERVERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_start,
    input  logic                           i_busy,
    input  tfa_pkg::t_req                  i_req,
    // reply channel
    input  logic                           i_done,
    input  tfa_pkg::t_rsp                  i_rsp,
    // register channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // status toward the top
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import tfa_pkg::*;

    // Shadow policy, capacities and server table
    logic [1:0]        fit_mode;
    logic [CORE_W-1:0] cap_cores;
    logic [MEM_W-1:0]  cap_mem;
    logic [CORE_W-1:0] free_cores [NUM_SERVERS];
    logic [MEM_W-1:0]  free_mem   [NUM_SERVERS];

    t_rsp pending_replies [$];
    int   fail_count;
    int   checked_count;

    // Every server back to full capacity
    task automatic refill_servers();
        for (int i = 0; i < NUM_SERVERS; i++) begin
            free_cores[i] = cap_cores;
            free_mem[i]   = cap_mem;
        end
    endtask

    // One line per mismatch, counted
    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Place or credit one request on the shadow table and return its reply
    function automatic t_rsp predict_placement(input t_req r);
        t_rsp               rsp;
        logic [CORE_W:0]    sum_c;
        logic [MEM_W:0]     sum_m;
        logic [WASTE_W-1:0] waste;
        logic [WASTE_W-1:0] best_waste;
        logic               found;
        logic               fits;
        int                 best;
        int                 tgt;
        rsp        = '0;
        rsp.status = ST_NOFIT;
        found      = 1'b0;
        best_waste = '0;
        best       = 0;
        tgt        = int'(r.target_server);
        if (r.op == OP_RELEASE) begin
            // credit with clamping; out-of-range targets are ignored
            if (tgt < NUM_SERVERS) begin
                sum_c      = {1'b0, free_cores[tgt]} + r.core_need;
                sum_m      = {1'b0, free_mem[tgt]} + r.memory_need;
                rsp.status = ST_RELEASE;
                if (sum_c > {1'b0, cap_cores}) begin
                    sum_c      = {1'b0, cap_cores};
                    rsp.status = ST_CLAMP;
                end
                if (sum_m > {1'b0, cap_mem}) begin
                    sum_m      = {1'b0, cap_mem};
                    rsp.status = ST_CLAMP;
                end
                free_cores[tgt]   = sum_c[CORE_W-1:0];
                free_mem[tgt]     = sum_m[MEM_W-1:0];
                rsp.chosen_server = r.target_server;
                rsp.cores_left    = free_cores[tgt];
                rsp.memory_left   = free_mem[tgt];
            end
        end else if (fit_mode <= FIT_WORST) begin
            // scan in index order; first fit stops at the first hit
            for (int i = 0; i < NUM_SERVERS; i++) begin
                fits = (free_cores[i] >= r.core_need) && (free_mem[i] >= r.memory_need);
                if (fits && !(found && fit_mode == FIT_FIRST)) begin
                    waste = WASTE_W'(free_cores[i] - r.core_need)
                          + WASTE_W'(free_mem[i] - r.memory_need);
                    if (!found) begin
                        found      = 1'b1;
                        best       = i;
                        best_waste = waste;
                    end else if ((fit_mode == FIT_BEST  && waste < best_waste) ||
                                 (fit_mode == FIT_WORST && waste > best_waste)) begin
                        best       = i;
                        best_waste = waste;
                    end
                end
            end
            if (found) begin
                free_cores[best]  = free_cores[best] - r.core_need;
                free_mem[best]    = free_mem[best] - r.memory_need;
                rsp.status        = ST_GRANT;
                rsp.chosen_server = SRV_W'(best);
                rsp.cores_left    = free_cores[best];
                rsp.memory_left   = free_mem[best];
            end
        end
        return rsp;
    endfunction

    // Per edge: check a reply beat, then apply any register beat and any request beat
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            fit_mode  = FIT_FIRST;
            cap_cores = RST_CORES;
            cap_mem   = RST_MEM;
            refill_servers();
            pending_replies.delete();
            fail_count    = 0;
            checked_count = 0;
        end else begin
            if (i_done) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch($sformatf("reply with none expected: status %0d server %0d",
                                              i_rsp.status, i_rsp.chosen_server));
                end else begin
                    want = pending_replies.pop_front();
                    checked_count++;
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  i_rsp.status, want.status));
                    if (i_rsp.chosen_server !== want.chosen_server)
                        report_mismatch($sformatf("chosen_server got %0d expected %0d",
                                                  i_rsp.chosen_server, want.chosen_server));
                    if (i_rsp.cores_left !== want.cores_left)
                        report_mismatch($sformatf("cores_left got %0d expected %0d",
                                                  i_rsp.cores_left, want.cores_left));
                    if (i_rsp.memory_left !== want.memory_left)
                        report_mismatch($sformatf("memory_left got %0d expected %0d",
                                                  i_rsp.memory_left, want.memory_left));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIT_MODE: begin
                        fit_mode = i_cfg_data[1:0];
                    end
                    CFG_CAP_CORES: begin
                        cap_cores = i_cfg_data[CORE_W-1:0];
                        refill_servers();
                    end
                    CFG_CAP_MEM: begin
                        cap_mem = i_cfg_data[MEM_W-1:0];
                        refill_servers();
                    end
                    default: begin
                    end
                endcase
            end
            // append the predicted reply behind the ones still outstanding
            if (i_start && !i_busy)
                pending_replies = {pending_replies, predict_placement(i_req)};
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_replies.size();
        o_checked    <= checked_count;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench top for the two resource fit allocator core
// Drives a directed opening and random request phases under several fit
// modes and capacities, with bursts and random sender gaps, and reports the
// verdict from the failure count of the reply checker.
// ============================================================================
module tb_top;
    import tfa_pkg::*;

    localparam int         NUM_SERVERS = NUM_SERVERS_DEF;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         REQ_W       = $bits(t_req);
    localparam logic [1:0] FIT_UNUSED  = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int requests_sent = 0;
    int settings_used = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    two_resource_fit_allocator_core #(
        .NUM_SERVERS (NUM_SERVERS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tfa_reply_checker #(
        .NUM_SERVERS (NUM_SERVERS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One request beat; returns right after the edge that took it
    task automatic issue_request(input logic op, input int cores, input int mem,
                                 input int tgt);
        t_req r;
        r.op            = op;
        r.core_need     = CORE_W'(cores);
        r.memory_need   = MEM_W'(mem);
        r.target_server = SRV_W'(tgt);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_sent++;
    endtask

    // Drop start and hold off until every expected reply has come back
    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Register beats back to back; mask bit i selects register i
    task automatic write_registers(input logic [2:0] mask, input logic [1:0] mode,
                                   input int cores, input int mem);
        logic [CFG_DATA_W-1:0] vals [3];
        vals[0] = CFG_DATA_W'(mode);
        vals[1] = CFG_DATA_W'(cores);
        vals[2] = CFG_DATA_W'(mem);
        drain_replies();
        for (int i = 0; i < 3; i++) begin
            if (mask[i]) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= CFG_IDX_W'(i);
                i_cfg_data  <= vals[i];
                @(posedge i_clk);
                while (!o_cfg_ready) @(posedge i_clk);
            end
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // One random phase under a single policy and capacity setting
    task automatic run_phase(input logic [1:0] mode, input int cores, input int mem,
                             input int items, input int idle_pct);
        logic op;
        int   cn;
        int   mn;
        int   tgt;
        write_registers(3'b111, mode, cores, mem);
        for (int n = 0; n < items; n++) begin
            // sender gaps, spread across the whole busy window and beyond
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                i_req <= t_req'(REQ_W'($urandom));
                repeat ($urandom_range(1, 135)) @(posedge i_clk);
            end else if ($urandom_range(0, 59) == 0) begin
                drain_replies();
            end
            op  = ($urandom_range(0, 99) < 35) ? OP_RELEASE : OP_ALLOC;
            tgt = $urandom_range(0, NUM_SERVERS - 1);
            if ($urandom_range(0, 9) == 0) begin
                // full field range, mostly oversized needs
                cn = $urandom_range(0, 31);
                mn = $urandom_range(0, 127);
            end else if (op == OP_RELEASE) begin
                cn = $urandom_range(0, (cores + 1) / 2);
                mn = $urandom_range(0, (mem + 1) / 2);
            end else begin
                cn = $urandom_range(0, cores);
                mn = $urandom_range(0, mem);
            end
            issue_request(op, cn, mn, tgt);
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FIT_MODE;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset capacities under first fit
        issue_request(OP_ALLOC,    0,   0,   0);
        issue_request(OP_ALLOC,   24,  64,   9);
        issue_request(OP_ALLOC,   31, 127,   0);
        issue_request(OP_ALLOC,    1,   1,   0);
        issue_request(OP_RELEASE,  0,   0,   5);
        issue_request(OP_RELEASE, 31, 127,   0);
        issue_request(OP_RELEASE,  1,   0,   1);
        issue_request(OP_RELEASE,  0,   1,   1);
        issue_request(OP_RELEASE,  1,   0, 127);
        issue_request(OP_ALLOC,   20,  10, 127);
        // best fit, then worst fit with a zero-leftover placement
        write_registers(3'b001, FIT_BEST, 0, 0);
        issue_request(OP_ALLOC,    2,   2,   0);
        issue_request(OP_ALLOC,    5,   5,   0);
        write_registers(3'b001, FIT_WORST, 0, 0);
        issue_request(OP_ALLOC,    3,   3,   0);
        issue_request(OP_ALLOC,   24,  64,   0);
        issue_request(OP_ALLOC,    4,  60,   0);
        // unused fit mode refuses allocates but still credits
        write_registers(3'b001, FIT_UNUSED, 0, 0);
        issue_request(OP_ALLOC,    0,   0,   0);
        issue_request(OP_RELEASE,  1,   1,   2);
        // zero capacities
        write_registers(3'b111, FIT_FIRST, 0, 0);
        issue_request(OP_ALLOC,    0,   0,   0);
        issue_request(OP_ALLOC,    1,   0,   0);
        issue_request(OP_RELEASE,  1,   1,   3);
        issue_request(OP_RELEASE,  0,   0,   3);
        // largest capacities
        write_registers(3'b111, FIT_FIRST, 31, 127);
        issue_request(OP_ALLOC,   31, 127,   0);
        issue_request(OP_ALLOC,   31, 127,   0);
        issue_request(OP_RELEASE, 31, 127,   0);

        // Random phases: policy, cores, memory, items, sender idle percent
        run_phase(FIT_FIRST, 24,  64, 139,  0);
        run_phase(FIT_BEST,   3,   8, 139, 79);
        run_phase(FIT_WORST,  3,   8, 139, 12);
        run_phase(FIT_FIRST,  1,   1, 139,  0);
        run_phase(FIT_BEST,  31, 127, 139, 79);
        run_phase(FIT_WORST, 31, 127, 139,  0);
        run_phase(FIT_BEST,   5,  20, 139, 12);
        run_phase(FIT_FIRST,  2, 127, 139, 79);
        run_phase(FIT_WORST, 31,   1, 139, 12);

        // Drain and let any stray reply show up
        drain_replies();
        repeat (NUM_SERVERS + 8) @(posedge i_clk);

        $display("Ran %0d requests over %0d register settings, %0d replies checked,",
                 requests_sent, settings_used, checked);
        $display("covering all fit modes, zero to full capacities and sender gaps.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### two_resource_fit_allocator_core.f
sv/tfa_pkg.sv
sv/tfa_cell.sv
sv/two_resource_fit_allocator_core.sv
tb/tfa_reply_checker.sv
tb/tb_top.sv
